@@ hdl/mdps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mdps_pkg;

  localparam int MAX_ELEMENTS = 16;
  localparam int VALUE_W = 32;
  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int COUNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int MASK_W = 16;
  localparam int SUM_W = 37;
  localparam int DIFF_W = 37;
  localparam int MATCH_W = 16;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic load;
    logic init;
    logic step;
    logic finish;
  } mdps_cmd_t;

  typedef struct packed {
    logic small_set;
    logic last_step;
    logic pipe_busy;
  } mdps_stat_t;

  // Position of the lowest set bit; the argument is never zero.
  function automatic logic [IDX_W-1:0] lowest_set(input logic [MASK_W-1:0] k);
    logic [IDX_W-1:0] pos;
    pos = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (k[i]) begin
        pos = IDX_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

@@ hdl/mdps_item_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface mdps_item_if;
  import mdps_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

@@ hdl/mdps_result_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface mdps_result_if;
  import mdps_pkg::*;

  logic                valid;
  logic                ready;
  logic [DIFF_W-1:0]   min_diff;
  logic [MASK_W-1:0]   best_mask;
  logic [MATCH_W-1:0]  match_count;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, output min_diff, output best_mask, output match_count, output status,
    input ready
  );
  modport sink (
    input valid, input min_diff, input best_mask, input match_count, input status,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/mdps_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mdps_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_last,
  output logic                    in_ready,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output mdps_pkg::mdps_cmd_t     cmd,
  input  wire mdps_pkg::mdps_stat_t stat
);
  import mdps_pkg::*;

  localparam logic [1:0] S_LOAD   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;

  assign in_ready = (state == S_LOAD);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.load = in_valid && in_ready;
    unique case (state)
      S_LOAD: begin
        if (in_valid && in_last) begin
          cmd.init = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.small_set) begin
          state_next = S_FINISH;
        end else begin
          cmd.step = 1'b1;
          if (stat.last_step) begin
            state_next = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/mdps_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mdps_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire mdps_pkg::mdps_cmd_t               cmd,
  output mdps_pkg::mdps_stat_t                   stat,
  input  wire logic signed [mdps_pkg::VALUE_W-1:0] value,
  output logic [mdps_pkg::DIFF_W-1:0]            min_diff,
  output logic [mdps_pkg::MASK_W-1:0]            best_mask,
  output logic [mdps_pkg::MATCH_W-1:0]           match_count,
  output logic [mdps_pkg::STATUS_W-1:0]          status
);
  import mdps_pkg::*;

  logic signed [VALUE_W-1:0] store [MAX_ELEMENTS];
  logic [COUNT_W-1:0]        count;
  logic signed [SUM_W-1:0]   total;
  logic                      overflowed;

  logic [MASK_W-1:0]         k;
  logic [MASK_W-1:0]         top;
  logic [MASK_W-1:0]         mask_a;
  logic signed [SUM_W-1:0]   sum_a;
  logic                      valid_a;
  logic signed [SUM_W:0]     diff_b;
  logic [MASK_W-1:0]         mask_b;
  logic                      valid_b;

  logic [DIFF_W-1:0]         run_min;
  logic [MASK_W-1:0]         run_best;
  logic [MATCH_W-1:0]        run_matches;

  logic                      full;
  logic [IDX_W-1:0]          flip_bit;
  logic [IDX_W-1:0]          elem_idx;
  logic signed [SUM_W-1:0]   elem;
  logic [SUM_W:0]            abs_b;
  logic [DIFF_W-1:0]         abs_diff;

  assign full = (count == COUNT_W'(MAX_ELEMENTS));
  assign flip_bit = lowest_set(k);
  assign elem_idx = IDX_W'(count - COUNT_W'(1) - COUNT_W'(flip_bit));
  assign elem = SUM_W'(store[elem_idx]);
  assign abs_b = diff_b[SUM_W] ? (SUM_W + 1)'(0) - diff_b : diff_b;
  assign abs_diff = DIFF_W'(abs_b);

  assign stat.small_set = (count < COUNT_W'(2));
  assign stat.last_step = (k == top);
  assign stat.pipe_busy = valid_a || valid_b;

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      store[count[IDX_W-1:0]] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
      overflowed <= 1'b0;
    end else if (cmd.finish) begin
      count <= '0;
      total <= '0;
      overflowed <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        overflowed <= 1'b1;
      end else begin
        count <= count + COUNT_W'(1);
        total <= total + SUM_W'(value);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
    end else begin
      valid_a <= cmd.step;
      valid_b <= valid_a && (mask_a != top);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      k <= MASK_W'(1);
      mask_a <= '0;
      sum_a <= '0;
    end else if (cmd.step) begin
      k <= k + MASK_W'(1);
      mask_a[flip_bit] <= ~mask_a[flip_bit];
      if (mask_a[flip_bit]) begin
        sum_a <= sum_a - elem;
      end else begin
        sum_a <= sum_a + elem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      top <= MASK_W'((MASK_W'(1) << count) - MASK_W'(1));
    end else if (cmd.init) begin
      top <= '1;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_a) begin
      diff_b <= (SUM_W + 1)'(total) - ((SUM_W + 1)'(sum_a) <<< 1);
      mask_b <= mask_a;
    end
  end

  // Ties keep the numerically smallest mask, which is the first one in counting order.
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      run_min <= '1;
      run_best <= '0;
      run_matches <= '0;
    end else if (valid_b) begin
      if (abs_diff < run_min) begin
        run_min <= abs_diff;
        run_best <= mask_b;
        run_matches <= MATCH_W'(1);
      end else if (abs_diff == run_min) begin
        if (mask_b < run_best) begin
          run_best <= mask_b;
        end
        if (run_matches != '1) begin
          run_matches <= run_matches + MATCH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (stat.small_set) begin
        min_diff <= '0;
        best_mask <= '0;
        match_count <= '0;
        status <= STATUS_SHORT;
      end else begin
        min_diff <= run_min;
        best_mask <= run_best;
        match_count <= run_matches;
        status <= overflowed ? STATUS_OVERFLOW : STATUS_OK;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/min_difference_partition_search.sv @@
// Loading takes one element per cycle; the input is held off from the final element until
// the result is registered, which also waits for the previous result to be taken. The search
// runs one subset per cycle in Gray-code order through a single shared accumulator, and is
// skipped when fewer than two elements are kept.
// Reset is synchronous and clears the element count, total, flags and the output valid;
// the element store itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module min_difference_partition_search (
  input  wire logic     clk,
  input  wire logic     rst,
  mdps_item_if.sink     items,
  mdps_result_if.source results
);
  import mdps_pkg::*;

  mdps_cmd_t  cmd;
  mdps_stat_t stat;

  mdps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_last   (items.last),
    .in_ready  (items.ready),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  mdps_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .value       (items.value),
    .min_diff    (results.min_diff),
    .best_mask   (results.best_mask),
    .match_count (results.match_count),
    .status      (results.status)
  );

endmodule

`default_nettype wire

@@ sim/min_difference_partition_search_tb.sv @@
`timescale 1ns / 1ps

module min_difference_partition_search_tb;
  import mdps_pkg::*;

  localparam int ITEM_TARGET = 1400;
  localparam int QUIET_FROM = ITEM_TARGET * 9 / 10;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int LARGE_FRAMES = 5;
  localparam longint DIFF_LIMIT = (64'sd1 <<< DIFF_W) - 64'sd1;
  localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef struct packed {
    logic [DIFF_W-1:0]   min_diff;
    logic [MASK_W-1:0]   best_mask;
    logic [MATCH_W-1:0]  match_count;
    logic [STATUS_W-1:0] status;
  } partition_result_t;

  class partition_scoreboard;
    longint elements[MAX_ELEMENTS];
    int kept;
    longint total;
    bit overflowed;
    longint subset_sums[];
    partition_result_t expected_partitions[$];
    int mismatches;

    function new();
      subset_sums = new[1 << MAX_ELEMENTS];
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      kept = 0;
      total = 0;
      overflowed = 1'b0;
    endfunction

    function partition_result_t search_partitions();
      partition_result_t r;
      longint d;
      longint ad;
      longint best_diff;
      int best_mask;
      int hits;
      int h;
      int top;
      r.min_diff = '0;
      r.best_mask = '0;
      r.match_count = '0;
      r.status = overflowed ? STATUS_OVERFLOW : STATUS_OK;
      if (kept < 2) begin
        r.status = STATUS_SHORT;
        return r;
      end
      top = (1 << kept) - 1;
      best_diff = DIFF_LIMIT;
      best_mask = 0;
      hits = 0;
      subset_sums[0] = 0;
      h = 0;
      for (int m = 1; m < top; m++) begin
        if (m == (2 << h)) begin
          h++;
        end
        // Mask bit h stands for element kept-1-h.
        subset_sums[m] = subset_sums[m ^ (1 << h)] + elements[kept - 1 - h];
        d = total - 2 * subset_sums[m];
        ad = (d < 0) ? -d : d;
        if (ad > DIFF_LIMIT) begin
          ad = DIFF_LIMIT;
        end
        if (ad < best_diff) begin
          best_diff = ad;
          best_mask = m;
          hits = 1;
        end else if (ad == best_diff && hits < 65535) begin
          hits++;
        end
      end
      r.min_diff = DIFF_W'(best_diff);
      r.best_mask = MASK_W'(best_mask);
      r.match_count = MATCH_W'(hits);
      return r;
    endfunction

    function void note_item(logic signed [VALUE_W-1:0] value, logic last);
      if (kept < MAX_ELEMENTS) begin
        elements[kept] = longint'(value);
        kept++;
        total += longint'(value);
      end else begin
        overflowed = 1'b1;
      end
      if (last) begin
        expected_partitions.insert(expected_partitions.size(), search_partitions());
        clear_frame();
      end
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    endtask

    task check_result(partition_result_t got);
      partition_result_t want;
      if (expected_partitions.size() == 0) begin
        report("result with nothing pending", 64'(got), 64'd0);
        return;
      end
      want = expected_partitions.pop_front();
      if (got.min_diff !== want.min_diff) begin
        report("min_diff", 64'(got.min_diff), 64'(want.min_diff));
      end
      if (got.best_mask !== want.best_mask) begin
        report("best_mask", 64'(got.best_mask), 64'(want.best_mask));
      end
      if (got.match_count !== want.match_count) begin
        report("match_count", 64'(got.match_count), 64'(want.match_count));
      end
      if (got.status !== want.status) begin
        report("status", 64'(got.status), 64'(want.status));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  bit quiet_phase;
  bit hold_request;
  int items_sent;
  partition_scoreboard sb;

  mdps_item_if item_bus ();
  mdps_result_if result_bus ();

  min_difference_partition_search u_dut (
    .clk(clk),
    .rst(rst),
    .items(item_bus),
    .results(result_bus)
  );

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  function automatic logic [VALUE_W-1:0] pick_value(int style);
    logic [VALUE_W-1:0] v;
    case (style)
      0: v = VALUE_W'($urandom);
      1: v = VALUE_W'($urandom_range(0, 16)) - VALUE_W'(8);
      2: begin
        case ($urandom_range(0, 4))
          0: v = VALUE_MAX;
          1: v = VALUE_MIN;
          2: v = '0;
          3: v = '1;
          default: v = VALUE_W'(1);
        endcase
      end
      default: v = VALUE_W'($urandom_range(0, 1000)) << $urandom_range(0, 20);
    endcase
    return v;
  endfunction

  task automatic send_item(logic [VALUE_W-1:0] value, logic last);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.value <= value;
    item_bus.last <= last;
    do begin
      @(posedge clk);
    end while (!item_bus.ready);
    sb.note_item(value, last);
    items_sent++;
    if (items_sent >= QUIET_FROM) begin
      quiet_phase = 1'b1;
    end
  endtask

  task automatic send_frame(int n, int style);
    int s;
    for (int i = 0; i < n; i++) begin
      s = (style > 3) ? $urandom_range(0, 3) : style;
      send_item(pick_value(s), i == n - 1);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      sb.check_result('{result_bus.min_diff, result_bus.best_mask,
                        result_bus.match_count, result_bus.status});
    end
  end

  initial begin : result_sink
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        result_bus.ready <= 1'b0;
      end else if (hold_request) begin
        result_bus.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
        hold_request = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(0, 12)) @(posedge clk);
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int n;
    int pick;
    int large_left;
    int frame_index;
    sb = new();
    quiet_phase = 1'b0;
    hold_request = 1'b0;
    items_sent = 0;
    large_left = LARGE_FRAMES;
    frame_index = 0;
    rst <= 1'b1;
    item_bus.valid <= 1'b0;
    item_bus.value <= '0;
    item_bus.last <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A single element leaves no proper subset to search.
    send_item(VALUE_MAX, 1'b1);
    send_item(VALUE_MIN, 1'b0);
    send_item(VALUE_MAX, 1'b1);
    send_item(VALUE_MIN, 1'b0);
    send_item(VALUE_MIN, 1'b1);
    send_item(VALUE_W'(1), 1'b0);
    send_item(VALUE_W'(1), 1'b0);
    send_item(VALUE_W'(2), 1'b1);
    // Seventeen elements overflow the store; the last one is dropped.
    for (int i = 0; i < MAX_ELEMENTS + 1; i++) begin
      send_item((i % 3 == 0) ? VALUE_MAX : (i % 3 == 1) ? VALUE_MIN : '1,
                i == MAX_ELEMENTS);
    end

    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        n = 1;
      end else if (pick < 86) begin
        n = $urandom_range(2, 6);
      end else if (pick < 96) begin
        n = $urandom_range(7, 10);
      end else if (large_left > 0) begin
        n = $urandom_range(11, MAX_ELEMENTS + 4);
        large_left--;
      end else begin
        n = $urandom_range(2, 6);
      end
      if (frame_index == 20) begin
        hold_request = 1'b1;
      end
      send_frame(n, $urandom_range(0, 4));
      frame_index++;
    end
    item_bus.valid <= 1'b0;

    while (sb.expected_partitions.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_partitions.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
